// File: hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/oms_pkg.sv
// Types and constants of the offboard mode sequencer
package oms_pkg;

  localparam int NOW_W = 63;
  localparam int CFG_W = 40;
  localparam int CFG_IDX_W = 2;

  // Item opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_NAV = 2'd1;
  localparam logic [1:0] OP_POS = 2'd2;
  localparam logic [1:0] OP_RESET = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_PRIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFBOARD_TO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_TO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_POSE = 2'd3;

  // Configuration reset values
  localparam logic [CFG_W-1:0] STREAM_PRIME_RST = 40'd250_000_000;
  localparam logic [CFG_W-1:0] OFFBOARD_TO_RST = 40'd8_000_000_000;
  localparam logic [CFG_W-1:0] ARM_TO_RST = 40'd8_000_000_000;
  localparam logic [CFG_W-1:0] STALE_POSE_RST = 40'd500_000_000;

  // State codes as seen on the result
  localparam logic [2:0] FSM_IDLE = 3'd0;
  localparam logic [2:0] FSM_HOLD = 3'd4;
  localparam logic [2:0] FSM_ERROR = 3'd7;

  // Setpoint source codes
  localparam logic [2:0] SRC_CURRENT = 3'd0;
  localparam logic [2:0] SRC_HOLD = 3'd1;
  localparam logic [2:0] SRC_CMD = 3'd2;
  localparam logic [2:0] SRC_NAV = 3'd3;
  localparam logic [2:0] SRC_SAFE = 3'd4;

  // Safe pose capture codes
  localparam logic [1:0] SAFE_NONE = 2'd0;
  localparam logic [1:0] SAFE_FROM_CURRENT = 2'd1;
  localparam logic [1:0] SAFE_FROM_CMD = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [NOW_W-1:0] now_ns;
    logic [NOW_W-1:0] pose_stamp_ns;
    logic             pose_finite;
    logic             pose_has_frame;
    logic             fcu_connected;
    logic             fcu_ready;
    logic             fcu_in_offboard;
    logic             fcu_armed;
    logic             offboard_rejected;
    logic             nav_reached;
    logic             position_close;
  } oms_in_t;

  typedef struct packed {
    logic [2:0] fsm_state;
    logic [2:0] setpoint_source;
    logic       cmd_position_mode;
    logic       cmd_offboard_mode;
    logic       cmd_arm;
    logic       cmd_nav_start;
    logic       cmd_nav_reset;
    logic       capture_hold;
    logic [1:0] capture_safe;
    logic       request_rejected;
    logic       accepts_commands;
  } oms_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] stream_prime_time;
    logic [CFG_W-1:0] offboard_timeout;
    logic [CFG_W-1:0] arm_timeout;
    logic [CFG_W-1:0] stale_pose_limit;
  } oms_cfg_t;

endpackage

// File: hdl/offboard_mode_sequencer.sv
// Offboard mode sequencer top level: config registers, item pipeline, result register
// Takes one item per clock while in_ready is high and gives one result item per item
// when the result side is not stalled, through an input register, then the
// transition logic into a result register. The longest path is the 63-bit
// elapsed-time subtract and timeout compare feeding the state update. Both
// stages stall together under out_ready low; a new item is taken while a
// finished result waits as long as the input register is free to move.
// Configuration writes take effect at once and are meant for idle periods.
module offboard_mode_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  oms_pkg::oms_in_t                  in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output oms_pkg::oms_out_t                 out_item,
  input  logic                              cfg_we,
  input  logic [oms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [oms_pkg::CFG_W-1:0]         cfg_wdata
);
  import oms_pkg::*;

  oms_cfg_t cfg_r;
  oms_in_t  item_r;
  logic     a_valid_r;
  oms_out_t out_r;
  logic     out_valid_r;
  oms_out_t res;
  logic     b_en;
  logic     adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stream_prime_time <= STREAM_PRIME_RST;
      cfg_r.offboard_timeout  <= OFFBOARD_TO_RST;
      cfg_r.arm_timeout       <= ARM_TO_RST;
      cfg_r.stale_pose_limit  <= STALE_POSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STREAM_PRIME: cfg_r.stream_prime_time <= cfg_wdata;
        REG_OFFBOARD_TO:  cfg_r.offboard_timeout  <= cfg_wdata;
        REG_ARM_TO:       cfg_r.arm_timeout       <= cfg_wdata;
        REG_STALE_POSE:   cfg_r.stale_pose_limit  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign b_en     = !out_valid_r || out_ready;
  assign adv      = a_valid_r && b_en;
  assign in_ready = !a_valid_r || b_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) a_valid_r <= in_valid;
      if (b_en) out_valid_r <= a_valid_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_item;
    if (adv) out_r <= res;
  end

  oms_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: hdl/oms_seq.sv
// Sequencer state and the per-item transition logic
module oms_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  oms_pkg::oms_in_t  item,
  input  oms_pkg::oms_cfg_t cfg,
  output oms_pkg::oms_out_t res
);
  import oms_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_STREAM   = 3'd1,
    ST_WAIT_OFF = 3'd2,
    ST_WAIT_ARM = 3'd3,
    ST_HOLD     = 3'd4,
    ST_POSITION = 3'd5,
    ST_NAV      = 3'd6,
    ST_ERROR    = 3'd7
  } state_t;

  state_t           state_r, state_nxt;
  logic [NOW_W-1:0] ent_r, ent_nxt;
  logic             nav_r, nav_nxt;
  logic             fr_r, fr_nxt;

  logic [NOW_W:0]   elapsed;
  logic [NOW_W:0]   pose_age;
  logic [CFG_W-1:0] lim;
  logic             waited;
  logic             tel_ok;
  logic             motion;

  // Time since state entry against the timeout of the current state
  assign elapsed = {1'b0, item.now_ns} - {1'b0, ent_r};
  always_comb begin
    case (state_r)
      ST_STREAM:   lim = cfg.stream_prime_time;
      ST_WAIT_OFF: lim = cfg.offboard_timeout;
      default:     lim = cfg.arm_timeout;
    endcase
  end
  assign waited = !elapsed[NOW_W] &&
                  (elapsed[NOW_W-1:0] >= {{(NOW_W-CFG_W){1'b0}}, lim});

  // Telemetry check: finite, and fresh unless unstamped; future stamps are bad
  assign pose_age = {1'b0, item.now_ns} - {1'b0, item.pose_stamp_ns};
  assign tel_ok = item.pose_finite &&
                  ((item.pose_stamp_ns == '0) ||
                   (!pose_age[NOW_W] &&
                    (pose_age[NOW_W-1:0] <= {{(NOW_W-CFG_W){1'b0}}, cfg.stale_pose_limit})));

  assign motion = (state_r != ST_IDLE) && (state_r != ST_ERROR);

  // Transition logic, evaluated in model order with blocking updates
  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    nav_nxt   = nav_r;
    fr_nxt    = fr_r;
    res       = '0;
    case (item.opcode)
      OP_RESET: begin
        state_nxt = ST_IDLE;
        ent_nxt   = item.now_ns;
        nav_nxt   = 1'b0;
        fr_nxt    = 1'b0;
      end
      OP_NAV, OP_POS: begin
        if (state_r == ST_IDLE || state_r == ST_HOLD) begin
          nav_nxt   = (item.opcode == OP_NAV);
          state_nxt = ST_STREAM;
          ent_nxt   = item.now_ns;
        end else begin
          res.request_rejected = 1'b1;
        end
      end
      OP_TICK: begin
        fr_nxt = item.pose_has_frame;
        if (state_r != ST_ERROR) begin
          if (motion && !tel_ok) begin
            // bad or stale telemetry while moving
            if (state_r == ST_NAV) res.cmd_nav_reset = 1'b1;
            res.capture_safe = fr_nxt ? SAFE_FROM_CURRENT : SAFE_FROM_CMD;
            state_nxt = ST_ERROR;
            ent_nxt   = item.now_ns;
          end else if (motion && (!item.fcu_connected || !item.fcu_ready)) begin
            // link trouble; hold rides it out
            if (state_r != ST_HOLD) begin
              if (state_r == ST_NAV) res.cmd_nav_reset = 1'b1;
              res.capture_safe = fr_nxt ? SAFE_FROM_CURRENT : SAFE_FROM_CMD;
              state_nxt = ST_ERROR;
              ent_nxt   = item.now_ns;
            end
          end else begin
            case (state_r)
              ST_STREAM: begin
                if (waited) begin
                  res.cmd_offboard_mode = 1'b1;
                  ent_nxt = item.now_ns;
                  if (item.offboard_rejected) begin
                    res.capture_safe = fr_nxt ? SAFE_FROM_CURRENT : SAFE_FROM_CMD;
                    state_nxt = ST_ERROR;
                  end else begin
                    state_nxt = ST_WAIT_OFF;
                  end
                end
              end
              ST_WAIT_OFF: begin
                if (waited) begin
                  res.capture_safe = fr_nxt ? SAFE_FROM_CURRENT : SAFE_FROM_CMD;
                  state_nxt = ST_ERROR;
                  ent_nxt   = item.now_ns;
                end else if (item.fcu_ready && item.fcu_in_offboard) begin
                  res.cmd_arm = 1'b1;
                  state_nxt = ST_WAIT_ARM;
                  ent_nxt   = item.now_ns;
                end
              end
              ST_WAIT_ARM: begin
                if (waited) begin
                  res.capture_safe = fr_nxt ? SAFE_FROM_CURRENT : SAFE_FROM_CMD;
                  state_nxt = ST_ERROR;
                  ent_nxt   = item.now_ns;
                end else if (item.fcu_ready && item.fcu_armed) begin
                  ent_nxt = item.now_ns;
                  if (nav_r) begin
                    res.cmd_nav_start = 1'b1;
                    state_nxt = ST_NAV;
                  end else begin
                    state_nxt = ST_POSITION;
                  end
                end
              end
              default: ;
            endcase
          end
          // arrival checks see the state reached so far in this item
          if (state_nxt == ST_NAV) begin
            if (item.nav_reached) begin
              res.capture_hold  = 1'b1;
              res.cmd_nav_reset = 1'b1;
              state_nxt = ST_HOLD;
              ent_nxt   = item.now_ns;
            end
          end else if (state_nxt == ST_POSITION) begin
            if (item.position_close) begin
              res.capture_hold = 1'b1;
              state_nxt = ST_HOLD;
              ent_nxt   = item.now_ns;
            end
          end
        end
      end
      default: ;
    endcase

    // Result fields from the state after the item
    res.fsm_state        = state_nxt;
    res.accepts_commands = (state_nxt == ST_IDLE) || (state_nxt == ST_HOLD);
    case (state_nxt)
      ST_HOLD:     res.setpoint_source = SRC_HOLD;
      ST_POSITION: res.setpoint_source = SRC_CMD;
      ST_NAV:      res.setpoint_source = SRC_NAV;
      ST_ERROR:    res.setpoint_source = SRC_SAFE;
      default:     res.setpoint_source = SRC_CURRENT;
    endcase
  end

  // State registers, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ent_r   <= '0;
      nav_r   <= 1'b0;
      fr_r    <= 1'b0;
    end else if (adv) begin
      state_r <= state_nxt;
      ent_r   <= ent_nxt;
      nav_r   <= nav_nxt;
      fr_r    <= fr_nxt;
    end
  end

endmodule

// File: hdl/oms_chk.sv
// Port-level checker for the offboard mode sequencer, bound to the top level
`include "assert_macros.svh"

module oms_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input oms_pkg::oms_out_t out_item
);
  import oms_pkg::*;

  logic idle_or_hold;
  logic safe_err;

  assign idle_or_hold = (out_item.fsm_state == FSM_IDLE) || (out_item.fsm_state == FSM_HOLD);
  assign safe_err     = (out_item.fsm_state == FSM_ERROR) &&
                        (out_item.setpoint_source == SRC_SAFE);

  // A stalled result stays put
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))

  // Command acceptance flag tracks idle or hold
  `ASSERT_IMP(a_accepts, clk, rst_n, out_valid, out_item.accepts_commands == idle_or_hold)

  // A refused request leaves the block outside idle and hold
  `ASSERT_IMP(a_reject, clk, rst_n, out_valid && out_item.request_rejected, !idle_or_hold)

  // A safe pose is captured only on the way into error
  `ASSERT_IMP(a_safe_err, clk, rst_n, out_valid && (out_item.capture_safe != SAFE_NONE), safe_err)

endmodule

bind offboard_mode_sequencer oms_chk u_oms_chk (.*);
